// ===== rtl/lbachs_pkg.sv =====
// Shared types and constants for the LBA to CHS task-file address block.
// Depends on nothing; the top level under rtl/ and the testbench use it.
`timescale 1ns / 1ps

package lbachs_pkg;

  localparam int unsigned LbaW     = 32;
  localparam int unsigned SptW     = 8;
  localparam int unsigned HcW      = 5;
  localparam int unsigned HeadW    = 4;
  localparam int unsigned PidxW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumParts = 4;

  // Quotient bits resolved per pipeline stage; must divide LbaW.
  localparam int unsigned DivBitsPerStage = 8;

  localparam logic [SptW-1:0] SptReset = 8'd63;
  localparam logic [HcW-1:0]  HcReset  = 5'd16;

  localparam logic [7:0] CmdReadSectors  = 8'h20;
  localparam logic [7:0] CmdWriteSectors = 8'h30;
  // Obsolete bits 7 and 5 of the drive/head register are always set.
  localparam logic [7:0] DriveHeadBase   = 8'h80 | 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSectorsPerTrack = 3'd0,
    CfgHeadCount       = 3'd1,
    CfgPartStartOne    = 3'd2,
    CfgPartStartTwo    = 3'd3,
    CfgPartStartThree  = 3'd4,
    CfgPartStartFour   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             operation;
    logic             drive_select;
    logic [PidxW-1:0] partition_index;
    logic [LbaW-1:0]  rel_lba;
  } req_t;

  typedef struct packed {
    logic [7:0]       sector_number;
    logic [HeadW-1:0] head_number;
    logic [7:0]       cylinder_low_byte;
    logic [7:0]       cylinder_high_byte;
    logic [7:0]       drive_head_byte;
    logic [7:0]       command_code;
    logic             cylinder_overflow;
  } taskfile_t;

endpackage

// ===== rtl/lbachs_div_pipe.sv =====
// Pipelined restoring divider: BITS_PER_STAGE quotient bits per register stage.
// Carries a sideband payload alongside; uses valid/ready between stages.
`timescale 1ns / 1ps

module lbachs_div_pipe #(
  parameter int unsigned DIVIDEND_W     = 32,
  parameter int unsigned DIVISOR_W      = 8,
  parameter int unsigned BITS_PER_STAGE = 8,
  parameter int unsigned SIDE_W         = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [DIVIDEND_W-1:0] quot_o,
  output logic [DIVISOR_W-1:0]  rem_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned NumStages = DIVIDEND_W / BITS_PER_STAGE;

  logic [NumStages-1:0]  vld_q;
  logic [NumStages:0]    rdy;
  logic [DIVIDEND_W-1:0] dq_q   [NumStages];
  logic [DIVISOR_W-1:0]  rem_q  [NumStages];
  logic [SIDE_W-1:0]     side_q [NumStages];

  assign rdy[NumStages] = ready_i;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic                  vld_in;
    logic [DIVIDEND_W-1:0] dq_in;
    logic [DIVISOR_W-1:0]  rem_in;
    logic [SIDE_W-1:0]     side_in;
    logic [DIVIDEND_W-1:0] dq_d;
    logic [DIVISOR_W-1:0]  rem_d;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign dq_in   = dividend_i;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign dq_in   = dq_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    // Dividend bits shift out the top while quotient bits shift in at the bottom.
    always_comb begin
      logic [DIVISOR_W:0] trial;
      trial = '0;
      rem_d = rem_in;
      dq_d  = dq_in;
      for (int b = 0; b < int'(BITS_PER_STAGE); b++) begin
        trial = {rem_d, dq_d[DIVIDEND_W-1]};
        dq_d  = {dq_d[DIVIDEND_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          trial   = trial - {1'b0, divisor_i};
          dq_d[0] = 1'b1;
        end
        rem_d = trial[DIVISOR_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vld_in) begin
        dq_q[s]   <= dq_d;
        rem_q[s]  <= rem_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];
  assign quot_o  = dq_q[NumStages-1];
  assign rem_o   = rem_q[NumStages-1];
  assign side_o  = side_q[NumStages-1];

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] |-> (rem_q[NumStages-1] < divisor_i))
    else $error("remainder not below divisor");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&vld_q))
    else $error("divider refuses input with a free stage");

  a_last_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-1] && !ready_i) |=>
      (vld_q[NumStages-1] && $stable(dq_q[NumStages-1]) && $stable(rem_q[NumStages-1])))
    else $error("stalled result changed");
`endif

endmodule

// ===== rtl/lba_to_chs_taskfile_address.sv =====
// Top level: LBA to CHS conversion into ATA task-file bytes.
// Uses lbachs_pkg and two lbachs_div_pipe instances.
`timescale 1ns / 1ps

// Usage
//   Request channel: in_valid_i / in_stall_o / in_data_i (lbachs_pkg::req_t).
//   Result channel: out_valid_o / out_stall_i / out_data_o (lbachs_pkg::taskfile_t).
//   A beat moves on a rising edge with valid high and stall low.
//   Geometry and partition starts are written through cfg_we_i / cfg_index_i /
//   cfg_data_i while no request is in flight; indexes above five are dropped.
// Pipeline: one offset-add stage, two chains of divider stages (sectors per track,
//   then heads), one format stage.
// Throughput: one request per cycle while in_stall_o stays low; every stage registers,
//   so a request can follow in the very next cycle unless the pipe is stalled.
// Reset: geometry returns to 63 sectors and 16 heads, partition starts to zero,
//   and all in-flight beats are dropped.
// Stall: a stalled result holds in the output register; upstream stages keep
//   filling bubbles and in_stall_o rises only once every stage holds a beat.
module lba_to_chs_taskfile_address #(
  parameter int unsigned DIV_BITS_PER_STAGE = lbachs_pkg::DivBitsPerStage
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbachs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lbachs_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lbachs_pkg::req_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lbachs_pkg::taskfile_t               out_data_o
);

  localparam int unsigned LbaW  = lbachs_pkg::LbaW;
  localparam int unsigned SptW  = lbachs_pkg::SptW;
  localparam int unsigned HcW   = lbachs_pkg::HcW;
  localparam int unsigned Side1W = 2;
  localparam int unsigned Side2W = 2 + SptW;

  // Configuration registers
  logic [SptW-1:0] spt_q;
  logic [HcW-1:0]  hc_q;
  logic [LbaW-1:0] part_start_q [lbachs_pkg::NumParts];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q <= lbachs_pkg::SptReset;
      hc_q  <= lbachs_pkg::HcReset;
      for (int i = 0; i < int'(lbachs_pkg::NumParts); i++) begin
        part_start_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (lbachs_pkg::cfg_reg_e'(cfg_index_i))
        lbachs_pkg::CfgSectorsPerTrack: spt_q <= cfg_data_i[SptW-1:0];
        lbachs_pkg::CfgHeadCount:       hc_q  <= cfg_data_i[HcW-1:0];
        lbachs_pkg::CfgPartStartOne:    part_start_q[0] <= cfg_data_i[LbaW-1:0];
        lbachs_pkg::CfgPartStartTwo:    part_start_q[1] <= cfg_data_i[LbaW-1:0];
        lbachs_pkg::CfgPartStartThree:  part_start_q[2] <= cfg_data_i[LbaW-1:0];
        lbachs_pkg::CfgPartStartFour:   part_start_q[3] <= cfg_data_i[LbaW-1:0];
        default: ;
      endcase
    end
  end

  // Zero geometry acts as one.
  logic [SptW-1:0] spt_eff;
  logic [HcW-1:0]  hc_eff;
  assign spt_eff = (spt_q == '0) ? SptW'(1) : spt_q;
  assign hc_eff  = (hc_q == '0) ? HcW'(1) : hc_q;

  // Offset-add stage
  logic [LbaW-1:0] offset;
  always_comb begin
    unique case (in_data_i.partition_index)
      3'd1:    offset = part_start_q[0];
      3'd2:    offset = part_start_q[1];
      3'd3:    offset = part_start_q[2];
      3'd4:    offset = part_start_q[3];
      default: offset = '0;
    endcase
  end

  logic             add_vld_q;
  logic             add_rdy;
  logic [LbaW-1:0]  abs_sec_q;
  logic [Side1W-1:0] add_side_q;
  logic             div1_ready;

  assign add_rdy    = !add_vld_q || div1_ready;
  assign in_stall_o = !add_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_vld_q <= 1'b0;
    end else if (add_rdy) begin
      add_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_rdy && in_valid_i) begin
      abs_sec_q  <= in_data_i.rel_lba + offset;
      add_side_q <= {in_data_i.operation, in_data_i.drive_select};
    end
  end

  // Divide by sectors per track
  logic              div1_vld;
  logic              div2_ready;
  logic [LbaW-1:0]   track;
  logic [SptW-1:0]   sec_rem;
  logic [Side1W-1:0] div1_side;

  lbachs_div_pipe #(
    .DIVIDEND_W     (LbaW),
    .DIVISOR_W      (SptW),
    .BITS_PER_STAGE (DIV_BITS_PER_STAGE),
    .SIDE_W         (Side1W)
  ) u_div_spt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .divisor_i  (spt_eff),
    .valid_i    (add_vld_q),
    .ready_o    (div1_ready),
    .dividend_i (abs_sec_q),
    .side_i     (add_side_q),
    .valid_o    (div1_vld),
    .ready_i    (div2_ready),
    .quot_o     (track),
    .rem_o      (sec_rem),
    .side_o     (div1_side)
  );

  // Divide by heads; remainder below 255 so the one-based sector fits 8 bits.
  logic              div2_vld;
  logic              out_rdy;
  logic [LbaW-1:0]   cyl;
  logic [HcW-1:0]    head_rem;
  logic [Side2W-1:0] div2_side;
  logic [SptW-1:0]   sector_one;

  assign sector_one = sec_rem + SptW'(1);

  lbachs_div_pipe #(
    .DIVIDEND_W     (LbaW),
    .DIVISOR_W      (HcW),
    .BITS_PER_STAGE (DIV_BITS_PER_STAGE),
    .SIDE_W         (Side2W)
  ) u_div_hc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .divisor_i  (hc_eff),
    .valid_i    (div1_vld),
    .ready_o    (div2_ready),
    .dividend_i (track),
    .side_i     ({div1_side, sector_one}),
    .valid_o    (div2_vld),
    .ready_i    (out_rdy),
    .quot_o     (cyl),
    .rem_o      (head_rem),
    .side_o     (div2_side)
  );

  // Format stage and output register
  logic                  out_vld_q;
  lbachs_pkg::taskfile_t out_d;
  lbachs_pkg::taskfile_t out_q;
  logic                  op_bit;
  logic                  drive_bit;
  logic [lbachs_pkg::HeadW-1:0] head;

  assign op_bit    = div2_side[Side2W-1];
  assign drive_bit = div2_side[Side2W-2];
  // Keep only four head bits so the drive bit stays clean.
  assign head      = head_rem[lbachs_pkg::HeadW-1:0];

  always_comb begin
    out_d.sector_number      = div2_side[SptW-1:0];
    out_d.head_number        = head;
    out_d.cylinder_low_byte  = cyl[7:0];
    out_d.cylinder_high_byte = cyl[15:8];
    out_d.drive_head_byte    = lbachs_pkg::DriveHeadBase | {3'b000, drive_bit, head};
    out_d.command_code       = op_bit ? lbachs_pkg::CmdWriteSectors
                                      : lbachs_pkg::CmdReadSectors;
    out_d.cylinder_overflow  = (cyl[LbaW-1:16] != '0);
  end

  assign out_rdy = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= div2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div2_vld) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_sector_one_based: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.sector_number != 8'd0))
    else $error("sector number zero on result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (add_vld_q && out_vld_q && div2_vld))
    else $error("request refused with a free stage");

  a_head_in_drive_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.drive_head_byte[3:0] == out_q.head_number))
    else $error("drive/head byte disagrees with head number");
`endif

endmodule

// ===== dv/lba_to_chs_taskfile_address_test.sv =====
// Self-checking testbench for lba_to_chs_taskfile_address: directed table, then random phases.
// Depends on rtl/lbachs_pkg.sv and the RTL of the block; results checked against known values or an in-file predictor.
`timescale 1ns / 1ps

module lba_to_chs_taskfile_address_test;

  localparam int unsigned LbaW     = lbachs_pkg::LbaW;
  localparam int unsigned SptW     = lbachs_pkg::SptW;
  localparam int unsigned HcW      = lbachs_pkg::HcW;
  localparam int unsigned HeadW    = lbachs_pkg::HeadW;
  localparam int unsigned PidxW    = lbachs_pkg::PidxW;
  localparam int unsigned CfgIdxW  = lbachs_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = lbachs_pkg::CfgDataW;
  localparam int unsigned NumParts = lbachs_pkg::NumParts;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpareSix   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareSeven = 3'd7;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned ItemsPerPhase  = 48;
  localparam int unsigned SettleCycles   = 12;

  typedef enum logic [1:0] {
    RowRequest,
    RowKnown,
    RowWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    lbachs_pkg::req_t      req;
    lbachs_pkg::taskfile_t known;
    logic [CfgIdxW-1:0]    index;
    logic [CfgDataW-1:0]   data;
  } plan_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  lbachs_pkg::req_t      in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  lbachs_pkg::taskfile_t out_data_o;

  // Shadow copy of the register file
  logic [SptW-1:0] spt_shadow;
  logic [HcW-1:0]  hc_shadow;
  logic [LbaW-1:0] part_start_shadow [NumParts];

  lbachs_pkg::taskfile_t expected_taskfiles [$];
  plan_row_t directed_plan [$];
  lbachs_pkg::taskfile_t result_want;
  int        mismatch_count = 0;
  int        stall_left     = 0;
  bit        sink_calm      = 1'b0;
  bit        source_calm    = 1'b0;
  bit        valid_raised   = 1'b0;

  lba_to_chs_taskfile_address u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic lbachs_pkg::taskfile_t predict_taskfile(lbachs_pkg::req_t r);
    lbachs_pkg::taskfile_t tf;
    logic [LbaW-1:0] spt;
    logic [LbaW-1:0] hc;
    logic [LbaW-1:0] offset;
    logic [LbaW-1:0] abs_sector;
    logic [LbaW-1:0] track;
    logic [LbaW-1:0] head;
    logic [LbaW-1:0] cylinder;
    logic [LbaW-1:0] sector;
    spt = (spt_shadow == 0) ? 32'd1 : 32'(spt_shadow);
    hc  = (hc_shadow == 0) ? 32'd1 : 32'(hc_shadow);
    offset = '0;
    if (r.partition_index >= 1 && r.partition_index <= NumParts) begin
      offset = part_start_shadow[r.partition_index - 1];
    end
    abs_sector = r.rel_lba + offset;
    sector     = abs_sector % spt + 32'd1;
    track      = abs_sector / spt;
    head       = track % hc;
    cylinder   = track / hc;
    tf.sector_number      = sector[7:0];
    // Keep only the low four head bits so the drive bit stays clean
    tf.head_number        = head[HeadW-1:0];
    tf.cylinder_low_byte  = cylinder[7:0];
    tf.cylinder_high_byte = cylinder[15:8];
    tf.drive_head_byte    = lbachs_pkg::DriveHeadBase
                            | {3'b000, r.drive_select, head[HeadW-1:0]};
    tf.command_code       = (r.operation == OpWrite) ? lbachs_pkg::CmdWriteSectors
                                                     : lbachs_pkg::CmdReadSectors;
    tf.cylinder_overflow  = (cylinder > 32'h0000_FFFF);
    return tf;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Check result beats and drive the result stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_taskfiles.size() == 0) begin
        $error("result beat with nothing expected: 0x%0h", out_data_o);
        mismatch_count++;
      end else begin
        result_want = expected_taskfiles.pop_front();
        check_field("sector_number", 32'(result_want.sector_number),
                    32'(out_data_o.sector_number));
        check_field("head_number", 32'(result_want.head_number),
                    32'(out_data_o.head_number));
        check_field("cylinder_low_byte", 32'(result_want.cylinder_low_byte),
                    32'(out_data_o.cylinder_low_byte));
        check_field("cylinder_high_byte", 32'(result_want.cylinder_high_byte),
                    32'(out_data_o.cylinder_high_byte));
        check_field("drive_head_byte", 32'(result_want.drive_head_byte),
                    32'(out_data_o.drive_head_byte));
        check_field("command_code", 32'(result_want.command_code),
                    32'(out_data_o.command_code));
        check_field("cylinder_overflow", 32'(result_want.cylinder_overflow),
                    32'(out_data_o.cylinder_overflow));
      end
      stall_left = sink_calm ? 0 : int'($urandom_range(0, 3));
    end else if (out_valid_o && out_stall_i && stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= rst_ni && (stall_left > 0);
  end

  task automatic add_request(logic op, logic drive, logic [PidxW-1:0] pidx,
                             logic [LbaW-1:0] lsec);
    plan_row_t row;
    row = '0;
    row.kind = RowRequest;
    row.req  = '{operation: op, drive_select: drive, partition_index: pidx,
                 rel_lba: lsec};
    directed_plan.push_back(row);
  endtask

  task automatic add_known(logic op, logic drive, logic [PidxW-1:0] pidx, logic [LbaW-1:0] lsec,
                           logic [7:0] sec, logic [HeadW-1:0] head, logic [7:0] cyl_lo,
                           logic [7:0] cyl_hi, logic [7:0] dh, logic [7:0] cmd, logic ovf);
    plan_row_t row;
    row = '0;
    row.kind  = RowKnown;
    row.req   = '{operation: op, drive_select: drive, partition_index: pidx,
                  rel_lba: lsec};
    row.known = '{sector_number: sec, head_number: head, cylinder_low_byte: cyl_lo,
                  cylinder_high_byte: cyl_hi, drive_head_byte: dh, command_code: cmd,
                  cylinder_overflow: ovf};
    directed_plan.push_back(row);
  endtask

  task automatic add_write(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind  = RowWrite;
    row.index = index;
    row.data  = data;
    directed_plan.push_back(row);
  endtask

  task automatic lower_valid();
    in_valid_i   <= 1'b0;
    valid_raised  = 1'b0;
    @(posedge clk_i);
  endtask

  // Present one request beat, hold it until accepted, then record what it should produce
  task automatic drive_request(lbachs_pkg::req_t req, int gap, bit has_known,
                               lbachs_pkg::taskfile_t known);
    if (gap > 0) begin
      if (valid_raised) begin
        lower_valid();
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    in_data_i    <= req;
    valid_raised  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_taskfiles.push_back(has_known ? known : predict_taskfile(req));
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    if (valid_raised) lower_valid();
    while (expected_taskfiles.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (index)
      lbachs_pkg::CfgSectorsPerTrack: spt_shadow = data[SptW-1:0];
      lbachs_pkg::CfgHeadCount:       hc_shadow  = data[HcW-1:0];
      lbachs_pkg::CfgPartStartOne, lbachs_pkg::CfgPartStartTwo,
      lbachs_pkg::CfgPartStartThree, lbachs_pkg::CfgPartStartFour:
        part_start_shadow[index - lbachs_pkg::CfgPartStartOne] = data;
      default: ;
    endcase
  endtask

  function automatic logic [LbaW-1:0] pick_start();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LbaW-1:0] pick_sector();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 4095);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    plan_row_t       row;
    lbachs_pkg::req_t req;
    logic [CfgDataW-1:0] data;
    logic [SptW-1:0] spt_pick;
    logic [HcW-1:0]  hc_pick;

    spt_shadow = lbachs_pkg::SptReset;
    hc_shadow  = lbachs_pkg::HcReset;
    foreach (part_start_shadow[p]) part_start_shadow[p] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: 63 sectors, 16 heads, all partitions at zero
    add_known(OpRead,  1'b0, 3'd0, 32'd0,         8'h01, 4'd0, 8'h00, 8'h00, 8'hA0,
              lbachs_pkg::CmdReadSectors, 1'b0);
    add_known(OpWrite, 1'b1, 3'd0, 32'hFFFF_FFFF, 8'h04, 4'd4, 8'h10, 8'h04, 8'hB4,
              lbachs_pkg::CmdWriteSectors, 1'b1);
    add_known(OpRead,  1'b0, 3'd0, 32'd62,        8'h3F, 4'd0, 8'h00, 8'h00, 8'hA0,
              lbachs_pkg::CmdReadSectors, 1'b0);
    add_known(OpRead,  1'b1, 3'd5, 32'd63,        8'h01, 4'd1, 8'h00, 8'h00, 8'hB1,
              lbachs_pkg::CmdReadSectors, 1'b0);
    add_known(OpWrite, 1'b0, 3'd7, 32'd1008,      8'h01, 4'd0, 8'h01, 8'h00, 8'hA0,
              lbachs_pkg::CmdWriteSectors, 1'b0);
    add_known(OpRead,  1'b1, 3'd6, 32'd1007,      8'h3F, 4'd15, 8'h00, 8'h00, 8'hBF,
              lbachs_pkg::CmdReadSectors, 1'b0);
    // Partition offsets, including the wrap past 2^32
    add_write(lbachs_pkg::CfgPartStartOne,   32'hFFFF_FFFF);
    add_write(lbachs_pkg::CfgPartStartTwo,   32'd100);
    add_write(lbachs_pkg::CfgPartStartThree, 32'h8000_0000);
    add_write(lbachs_pkg::CfgPartStartFour,  32'h1234_5678);
    add_request(OpRead,  1'b0, 3'd1, 32'd1);
    add_request(OpWrite, 1'b1, 3'd1, 32'hFFFF_FFFF);
    add_request(OpRead,  1'b1, 3'd2, 32'd0);
    add_request(OpWrite, 1'b0, 3'd3, 32'h7FFF_FFFF);
    add_request(OpRead,  1'b1, 3'd4, 32'hEDCB_A987);
    // Zero geometry acts as one: cylinder equals the absolute sector
    add_write(lbachs_pkg::CfgSectorsPerTrack, 32'd0);
    add_write(lbachs_pkg::CfgHeadCount,       32'd0);
    add_request(OpRead,  1'b0, 3'd0, 32'h0000_FFFF);
    add_request(OpWrite, 1'b1, 3'd0, 32'h0001_0000);
    // Largest geometry the registers hold
    add_write(lbachs_pkg::CfgSectorsPerTrack, 32'd255);
    add_write(lbachs_pkg::CfgHeadCount,       32'd31);
    add_request(OpWrite, 1'b1, 3'd0, 32'hFFFF_FFFF);
    add_request(OpRead,  1'b0, 3'd2, 32'h0001_2345);
    // Head of sixteen must not leak into the drive bit
    add_write(lbachs_pkg::CfgSectorsPerTrack, 32'd1);
    add_write(lbachs_pkg::CfgHeadCount,       32'd17);
    add_request(OpRead,  1'b1, 3'd0, 32'd16);
    add_request(OpWrite, 1'b0, 3'd0, 32'd33);
    // Writes to unused indexes are dropped
    add_write(CfgSpareSix,   32'd0);
    add_write(CfgSpareSeven, 32'hFFFF_FFFF);
    add_request(OpRead,  1'b1, 3'd0, 32'hFFFF_FFFE);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == RowWrite) begin
        if (i == 0 || directed_plan[i-1].kind != RowWrite) drain_results();
        write_register(row.index, row.data);
        if (i + 1 == directed_plan.size() || directed_plan[i+1].kind != RowWrite) begin
          cfg_we_i <= 1'b0;
        end
      end else begin
        drive_request(row.req, int'($urandom_range(0, 3)), row.kind == RowKnown, row.known);
      end
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain_results();
      case (phase)
        0:       begin spt_pick = 8'd255; hc_pick = 5'd16; end
        1:       begin spt_pick = 8'd1;   hc_pick = 5'd1;  end
        2:       begin spt_pick = 8'd0;   hc_pick = 5'd0;  end
        3:       begin spt_pick = SptW'($urandom_range(1, 255)); hc_pick = 5'd31; end
        default: begin spt_pick = SptW'($urandom); hc_pick = HcW'($urandom_range(1, 16)); end
      endcase
      // Upper data bits beyond a register's width are don't-care
      data = $urandom;
      data[SptW-1:0] = spt_pick;
      write_register(lbachs_pkg::CfgSectorsPerTrack, data);
      data = $urandom;
      data[HcW-1:0] = hc_pick;
      write_register(lbachs_pkg::CfgHeadCount, data);
      write_register(lbachs_pkg::CfgPartStartOne,   pick_start());
      write_register(lbachs_pkg::CfgPartStartTwo,   pick_start());
      write_register(lbachs_pkg::CfgPartStartThree, pick_start());
      write_register(lbachs_pkg::CfgPartStartFour,  pick_start());
      if ($urandom_range(0, 1)) begin
        write_register(($urandom_range(0, 1) != 0) ? CfgSpareSeven : CfgSpareSix, $urandom);
      end
      cfg_we_i <= 1'b0;
      source_calm = (phase % 3 == 1);
      sink_calm   = (phase % 3 == 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        req.operation       = 1'($urandom_range(0, 1));
        req.drive_select    = 1'($urandom_range(0, 1));
        req.partition_index = PidxW'($urandom_range(0, 7));
        req.rel_lba         = pick_sector();
        drive_request(req, source_calm ? 0 : int'($urandom_range(0, 3)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_taskfiles.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lbachs_pkg.sv
rtl/lbachs_div_pipe.sv
rtl/lba_to_chs_taskfile_address.sv
dv/lba_to_chs_taskfile_address_test.sv
